// ----- sv/etc1_pkg.sv -----
// Shared types, constants and helpers for the ETC1 block decoder.
// No dependencies; every other file imports this package.
package etc1_pkg;

  // Default depth of the queue between the front and back ends
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input beat: one color block plus its alpha word
  typedef struct packed {
    logic [63:0] color_word;
    logic [63:0] alpha_word;
  } in_beat_t;

  // Output beat: one decoded pixel
  typedef struct packed {
    logic [1:0] pixel_x;
    logic [1:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } out_beat_t;

  // Classified block, handed from front to back through the queue
  typedef struct packed {
    logic [7:0]  base1_r;
    logic [7:0]  base1_g;
    logic [7:0]  base1_b;
    logic [7:0]  base2_r;
    logic [7:0]  base2_g;
    logic [7:0]  base2_b;
    logic [2:0]  tab1;
    logic [2:0]  tab2;
    logic        flip;
    logic [15:0] idx_lo;
    logic [15:0] idx_hi;
    logic [63:0] alpha_word;
  } blk_desc_t;

  // 4-bit to 8-bit expansion by replication
  function automatic logic [7:0] widen4(input logic [3:0] n);
    return {n, n};
  endfunction

  // 5-bit to 8-bit expansion, top bits copied into the low end
  function automatic logic [7:0] widen5(input logic [4:0] n);
    return {n, n[4:2]};
  endfunction

  // Modifier magnitude: sel_big picks the larger entry of the table row
  function automatic logic [7:0] mod_mag(input logic [2:0] tab, input logic sel_big);
    logic [7:0] small_v;
    logic [7:0] big_v;
    begin
      unique case (tab)
        3'd0: begin small_v = 8'd2;  big_v = 8'd8;   end
        3'd1: begin small_v = 8'd5;  big_v = 8'd17;  end
        3'd2: begin small_v = 8'd9;  big_v = 8'd29;  end
        3'd3: begin small_v = 8'd13; big_v = 8'd42;  end
        3'd4: begin small_v = 8'd18; big_v = 8'd60;  end
        3'd5: begin small_v = 8'd24; big_v = 8'd80;  end
        3'd6: begin small_v = 8'd33; big_v = 8'd106; end
        3'd7: begin small_v = 8'd47; big_v = 8'd183; end
        default: begin small_v = 8'd0; big_v = 8'd0; end
      endcase
      return sel_big ? big_v : small_v;
    end
  endfunction

endpackage

// ----- sv/etc1_front.sv -----
// Front end: accepts color/alpha beats and classifies each block into
// base colours, table codes and pixel indices. Depends on etc1_pkg.
module etc1_front import etc1_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      push_valid,
  input  logic      push_ready,
  output blk_desc_t push_data
);

  logic      fr_valid_r, fr_valid_nxt;
  blk_desc_t fr_desc_r, fr_desc_nxt;
  logic      accept;

  // Bases for one channel: byte holds both 4-bit values or base5 + delta3
  function automatic logic [15:0] chan_bases(input logic [7:0] b, input logic diff);
    logic [4:0] sum5;
    begin
      sum5 = b[7:3] + {{2{b[2]}}, b[2:0]};
      if (diff) begin
        return {widen5(b[7:3]), widen5(sum5)};
      end else begin
        return {widen4(b[7:4]), widen4(b[3:0])};
      end
    end
  endfunction

  // Holding register stalls only while the queue refuses it
  assign in_stall = fr_valid_r && !push_ready;
  assign accept   = in_valid && !in_stall;

  // Classify the incoming block
  always_comb begin
    logic [15:0] rb, gb, bb;
    logic        diff;
    diff = in_data.color_word[33];
    rb   = chan_bases(in_data.color_word[63:56], diff);
    gb   = chan_bases(in_data.color_word[55:48], diff);
    bb   = chan_bases(in_data.color_word[47:40], diff);
    fr_desc_nxt.base1_r    = rb[15:8];
    fr_desc_nxt.base2_r    = rb[7:0];
    fr_desc_nxt.base1_g    = gb[15:8];
    fr_desc_nxt.base2_g    = gb[7:0];
    fr_desc_nxt.base1_b    = bb[15:8];
    fr_desc_nxt.base2_b    = bb[7:0];
    fr_desc_nxt.tab1       = in_data.color_word[39:37];
    fr_desc_nxt.tab2       = in_data.color_word[36:34];
    fr_desc_nxt.flip       = in_data.color_word[32];
    fr_desc_nxt.idx_lo     = in_data.color_word[15:0];
    fr_desc_nxt.idx_hi     = in_data.color_word[31:16];
    fr_desc_nxt.alpha_word = in_data.alpha_word;
  end

  // Valid tracking of the holding register
  always_comb begin
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (push_ready) begin
      fr_valid_nxt = 1'b0;
    end else begin
      fr_valid_nxt = fr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_desc_r <= fr_desc_nxt;
    end
  end

  assign push_valid = fr_valid_r;
  assign push_data  = fr_desc_r;

endmodule

// ----- sv/etc1_queue.sv -----
// Short FIFO of classified blocks between front and back ends.
// Depends on etc1_pkg for the descriptor type.
module etc1_queue import etc1_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  blk_desc_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output blk_desc_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  blk_desc_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/etc1_back.sv -----
// Back end: walks the sixteen pixels of a classified block, one per beat,
// into a registered output stage. Depends on etc1_pkg.
module etc1_back import etc1_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      alpha_en,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  blk_desc_t pop_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  blk_desc_t cur_r, cur_nxt;
  logic      busy_r, busy_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_r, out_nxt;
  logic      adv, done, take;

  // Sequencing
  assign adv       = busy_r && (!out_valid_r || !out_stall);
  assign done      = adv && (cnt_r == 4'd15);
  assign pop_ready = !busy_r || done;
  assign take      = pop_ready && pop_valid;

  always_comb begin
    cur_nxt  = take ? pop_data : cur_r;
    busy_nxt = take ? 1'b1 : (done ? 1'b0 : busy_r);
    if (take) begin
      cnt_nxt = 4'd0;
    end else if (adv) begin
      cnt_nxt = cnt_r + 4'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
    out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // Clamp base + modifier to 0..255
  function automatic logic [7:0] sat_add(input logic [7:0] base, input logic [7:0] mag,
                                         input logic neg);
    logic signed [9:0] s;
    begin
      s = neg ? ($signed({2'b00, base}) - $signed({2'b00, mag}))
              : ($signed({2'b00, base}) + $signed({2'b00, mag}));
      if (s < 0) begin
        return 8'd0;
      end else if (s > 10'sd255) begin
        return 8'd255;
      end else begin
        return s[7:0];
      end
    end
  endfunction

  // Current pixel
  always_comb begin
    logic       sb;
    logic [1:0] idx;
    logic [2:0] tab;
    logic [7:0] mag;
    logic [3:0] nib;
    sb  = cur_r.flip ? cnt_r[1] : cnt_r[3];
    idx = {cur_r.idx_hi[cnt_r], cur_r.idx_lo[cnt_r]};
    tab = sb ? cur_r.tab2 : cur_r.tab1;
    mag = mod_mag(tab, idx[0]);
    nib = cur_r.alpha_word[{cnt_r, 2'b00} +: 4];
    out_nxt.pixel_x = cnt_r[3:2];
    out_nxt.pixel_y = cnt_r[1:0];
    out_nxt.red     = sat_add(sb ? cur_r.base2_r : cur_r.base1_r, mag, idx[1]);
    out_nxt.green   = sat_add(sb ? cur_r.base2_g : cur_r.base1_g, mag, idx[1]);
    out_nxt.blue    = sat_add(sb ? cur_r.base2_b : cur_r.base1_b, mag, idx[1]);
    out_nxt.alpha   = alpha_en ? widen4(nib) : 8'hFF;
    out_nxt.last    = (cnt_r == 4'd15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sv/etc1_block_decode.sv -----
// ETC1 block decoder top level: front end, block queue and pixel back end.
// Depends on etc1_pkg, etc1_front, etc1_queue and etc1_back.
//
// Each accepted beat is one 64-bit ETC1 block with its 64-bit alpha word; the
// block answers with sixteen pixel beats in column-major order, the sixteenth
// flagged last. The result port carries one pixel per cycle while out_stall is
// low; a block passes the holding register, queue and back end's block register
// before its first pixel leaves the output register. The front end registers
// and classifies a block while the back end is still emitting the previous
// one, and the queue (QDEPTH entries) absorbs further blocks, so the input is
// not held off until the queue and holding register are full. cfg_we/cfg_wdata
// set alpha_enable and should only change while no block is in flight.
module etc1_block_decode import etc1_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic      alpha_en_r;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  blk_desc_t push_data, pop_data;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_en_r <= 1'b0;
    end else if (cfg_we) begin
      alpha_en_r <= cfg_wdata;
    end
  end

  etc1_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  etc1_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  etc1_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .alpha_en  (alpha_en_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sv/etc1_checker.sv -----
// Port-level checks for etc1_block_decode, bound to the top level.
// Depends on etc1_pkg for the beat types.
module etc1_checker import etc1_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      cfg_we,
  input logic      cfg_wdata,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  logic [3:0] pix_cnt_r;
  logic       alpha_en_r;
  logic       out_acc;

  assign out_acc = out_valid && !out_stall;

  // Shadow of the pixel position and of the config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r  <= 4'd0;
      alpha_en_r <= 1'b0;
    end else begin
      if (out_acc) begin
        pix_cnt_r <= pix_cnt_r + 4'd1;
      end
      if (cfg_we) begin
        alpha_en_r <= cfg_wdata;
      end
    end
  end

  // A stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Pixels leave in column-major order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (out_data.pixel_x == pix_cnt_r[3:2]) && (out_data.pixel_y == pix_cnt_r[1:0]))
    else $error("pixel out of order");

  // Last flag only on the sixteenth pixel
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (out_data.last == (pix_cnt_r == 4'd15)))
    else $error("last flag misplaced");

  // Opaque alpha when alpha is disabled
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !alpha_en_r |-> (out_data.alpha == 8'hFF))
    else $error("alpha not opaque while disabled");

endmodule

bind etc1_block_decode etc1_checker u_etc1_checker (.*);

// ----- tb/tb_etc1_block_decode.sv -----
// Self-checking testbench for etc1_block_decode: ETC1 blocks in, checked RGBA pixels out.
// Depends on etc1_pkg (beat types) and the etc1_block_decode RTL; the expected-pixel
// scoreboard class is declared inside the top module.
module tb_etc1_block_decode;
  timeunit 1ns;
  timeprecision 1ps;
  import etc1_pkg::*;

  // Decodes each accepted block into its sixteen expected pixels and matches output beats
  class decoded_pixels;
    bit        alpha_on;
    out_beat_t pending_px[$];
    int        mismatches;
    int        blocks_seen;
    int        pixels_matched;
    int        mods [8][4] = '{'{  2,   8,  -2,   -8}, '{  5,  17,  -5,  -17},
                               '{  9,  29,  -9,  -29}, '{ 13,  42, -13,  -42},
                               '{ 18,  60, -18,  -60}, '{ 24,  80, -24,  -80},
                               '{ 33, 106, -33, -106}, '{ 47, 183, -47, -183}};

    function logic [7:0] grow4(logic [3:0] n);
      return {n, n};
    endfunction

    function logic [7:0] grow5(logic [4:0] n);
      return {n, n[4:2]};
    endfunction

    function logic [7:0] clamp8(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    // Expected pixels of one block, column-major, pushed in output order
    function void add_block(in_beat_t b);
      logic [63:0] cw;
      logic [7:0]  base [2][3];
      logic [2:0]  tab [2];
      logic [4:0]  b5;
      logic [4:0]  d5;
      logic [4:0]  sum5;
      logic [1:0]  code;
      logic [1:0]  x;
      logic [1:0]  y;
      int          sh;
      int          sel;
      int          m;
      out_beat_t   px;
      cw = b.color_word;
      tab[0] = cw[39:37];
      tab[1] = cw[36:34];
      // base colours: R at 63..56, G at 55..48, B at 47..40
      for (int ch = 0; ch < 3; ch++) begin
        sh = 56 - 8 * ch;
        if (cw[33]) begin
          b5   = cw[sh+3 +: 5];
          d5   = {{2{cw[sh+2]}}, cw[sh +: 3]};
          sum5 = b5 + d5;
          base[0][ch] = grow5(b5);
          base[1][ch] = grow5(sum5);
        end else begin
          base[0][ch] = grow4(cw[sh+4 +: 4]);
          base[1][ch] = grow4(cw[sh +: 4]);
        end
      end
      for (int i = 0; i < 16; i++) begin
        x    = 2'(i >> 2);
        y    = 2'(i & 3);
        code = {cw[16+i], cw[i]};
        sel  = cw[32] ? int'(y[1]) : int'(x[1]);
        m    = mods[tab[sel]][code];
        px.pixel_x = x;
        px.pixel_y = y;
        px.red     = clamp8(int'(base[sel][0]) + m);
        px.green   = clamp8(int'(base[sel][1]) + m);
        px.blue    = clamp8(int'(base[sel][2]) + m);
        px.alpha   = alpha_on ? grow4(b.alpha_word[4*i +: 4]) : 8'hFF;
        px.last    = (i == 15);
        pending_px.push_back(px);
      end
      blocks_seen++;
    endfunction

    function void field_eq(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one output beat against the oldest expected pixel
    function void match_pixel(out_beat_t got);
      out_beat_t want;
      if (pending_px.size() == 0) begin
        $error("pixel beat with no block outstanding: %h", got);
        mismatches++;
        return;
      end
      want = pending_px.pop_front();
      pixels_matched++;
      field_eq("pixel_x", 8'(want.pixel_x), 8'(got.pixel_x));
      field_eq("pixel_y", 8'(want.pixel_y), 8'(got.pixel_y));
      field_eq("red",     want.red,         got.red);
      field_eq("green",   want.green,       got.green);
      field_eq("blue",    want.blue,        got.blue);
      field_eq("alpha",   want.alpha,       got.alpha);
      field_eq("last",    8'(want.last),    8'(got.last));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic      cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  bit            no_idle;
  int            hold_len;
  decoded_pixels px;

  etc1_block_decode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, well above the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Input beats feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) px.add_block(in_data);
  end

  // Output beats are checked against it
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) px.match_pixel(out_data);
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (rst_n && !no_idle && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_beat_t build(logic [23:0] colours, logic [2:0] t1, logic [2:0] t2,
                                     logic diff, logic flip, logic [31:0] idx,
                                     logic [63:0] aw);
    in_beat_t b;
    b.color_word = {colours, t1, t2, diff, flip, idx};
    b.alpha_word = aw;
    return b;
  endfunction

  function automatic in_beat_t random_block();
    in_beat_t b;
    b.color_word = {$urandom, $urandom};
    b.alpha_word = {$urandom, $urandom};
    // a quarter of blocks pin colour nibbles to the rails to hit clamps and wraps
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(0, 2))
          0:       b.color_word[40+4*k +: 4] = 4'h0;
          1:       b.color_word[40+4*k +: 4] = 4'hF;
          default: ;
        endcase
      end
    end
    return b;
  endfunction

  // Offer one block and hold it until the beat is taken
  task automatic send_block(input in_beat_t b, input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && !no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every expected pixel has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (px.pending_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write, with cfg_we dropped before anything else is driven
  task automatic set_alpha_enable(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    px.alpha_on = v;
    @(posedge clk);
  endtask

  initial begin
    logic [2:0] t;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    rst_n     = 1'b0;
    no_idle   = 1'b0;
    hold_len  = 0;
    px = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opaque after reset: alpha word must be ignored
    send_block(build(24'h000000, 3'd0, 3'd0, 1'b0, 1'b0, 32'h0, 64'h0), 1'b1);
    send_block(build(24'hFFFFFF, 3'd7, 3'd7, 1'b1, 1'b1, 32'hFFFFFFFF, '1), 1'b1);
    wait_drained();
    set_alpha_enable(1'b1);

    // clamps at both rails
    send_block(build(24'hFFFFFF, 3'd7, 3'd7, 1'b0, 1'b0, 32'h0000FFFF, '1), 1'b1);
    send_block(build(24'h000000, 3'd7, 3'd7, 1'b0, 1'b1, 32'hFFFFFFFF, 64'h0), 1'b1);
    // differential: wrap past 31, wrap below 0, big negative delta, zero delta
    send_block(build(24'hFBFBFB, 3'd3, 3'd5, 1'b1, 1'b0, $urandom, {$urandom, $urandom}), 1'b1);
    send_block(build(24'h040404, 3'd2, 3'd6, 1'b1, 1'b1, $urandom, {$urandom, $urandom}), 1'b1);
    send_block(build(24'hFCFCFC, 3'd1, 3'd4, 1'b1, 1'b0, $urandom, {$urandom, $urandom}), 1'b1);
    send_block(build(24'h808080, 3'd0, 3'd7, 1'b1, 1'b1, $urandom, {$urandom, $urandom}), 1'b1);
    // individual mode, both split directions
    send_block(build(24'($urandom), 3'd4, 3'd1, 1'b0, 1'b0, $urandom, {$urandom, $urandom}),
               1'b1);
    send_block(build(24'($urandom), 3'd5, 3'd2, 1'b0, 1'b1, $urandom, {$urandom, $urandom}),
               1'b1);
    // every intensity table in both sub-blocks
    for (int k = 0; k < 8; k++) begin
      t = 3'(k);
      send_block(build(24'($urandom), t, ~t, t[0], t[1], $urandom, 64'hFEDCBA9876543210),
                 1'b1);
    end
    send_block(build(24'h000000, 3'd0, 3'd0, 1'b0, 1'b0, 32'h0, 64'h0123456789ABCDEF), 1'b1);
    wait_drained();
    set_alpha_enable(1'b0);

    // random, opaque, idling on both sides
    for (int n = 0; n < 120; n++) send_block(random_block(), 1'b1);

    // long output hold-off while the sender keeps offering back to back
    hold_len = 250;
    for (int n = 0; n < 12; n++) send_block(random_block(), 1'b0);
    wait_drained();
    set_alpha_enable(1'b1);

    // random with alpha, idling on both sides
    for (int n = 0; n < 120; n++) send_block(random_block(), 1'b1);
    wait_drained();
    set_alpha_enable(1'b0);
    set_alpha_enable(1'b1);

    // last stretch at full rate, no idling
    no_idle = 1'b1;
    for (int n = 0; n < 120; n++) send_block(random_block(), 1'b1);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Decoded %0d blocks, %0d pixels compared; both modes, both splits, all tables,",
             px.blocks_seen, px.pixels_matched);
    $display("alpha on and off, rail clamps, delta wraps, random stalls and a long hold-off.");
    if (px.mismatches == 0 && px.pending_px.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/etc1_pkg.sv
sv/etc1_front.sv
sv/etc1_queue.sv
sv/etc1_back.sv
sv/etc1_block_decode.sv
sv/etc1_checker.sv
tb/tb_etc1_block_decode.sv
